### rtl/earliest_free_server_dispatch_assert.svh
// Assertion macros for the earliest-free-server dispatch block.
// Each macro expects clk_i and rst_ni in the scope where it is used.
`ifndef EARLIEST_FREE_SERVER_DISPATCH_ASSERT_SVH
`define EARLIEST_FREE_SERVER_DISPATCH_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define EFSD_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define EFSD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/efsd_pkg.sv
// Package for the earliest-free-server dispatch block: sizes, item types,
// status codes and queue pointer helpers. It depends on nothing else.
package efsd_pkg;

  localparam int SERVERS     = 4;
  localparam int QUEUE_DEPTH = 16;

  localparam int TIME_W  = 11;
  localparam int SVC_W   = 8;
  localparam int SIDX_W  = 2;
  localparam int AHEAD_W = 5;

  localparam int SRV_W     = (SERVERS > 1) ? $clog2(SERVERS) : 1;
  localparam int PTR_W     = $clog2(QUEUE_DEPTH);
  localparam int FILL_W    = $clog2(QUEUE_DEPTH + 1);
  localparam int SUM_W     = $clog2(2 * QUEUE_DEPTH);
  localparam int MEM_DEPTH = SERVERS * QUEUE_DEPTH;
  localparam int ADDR_W    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

  localparam logic [TIME_W-1:0] TIME_MAX      = '1;
  localparam logic [TIME_W-1:0] CLOSING_RESET = TIME_W'(17 * 60);

  typedef enum logic [1:0] {
    ST_IDLE   = 2'd0,
    ST_QUEUED = 2'd1,
    ST_CLOSED = 2'd2,
    ST_FULL   = 2'd3
  } status_e;

  typedef struct packed {
    logic [TIME_W-1:0] arrival_minute;
    logic [SVC_W-1:0]  service_minutes;
  } in_item_t;

  typedef struct packed {
    logic [SIDX_W-1:0]  server_index;
    status_e            status;
    logic [TIME_W-1:0]  wait_minutes;
    logic [TIME_W-1:0]  start_minute;
    logic [TIME_W-1:0]  end_minute;
    logic [AHEAD_W-1:0] ahead_count;
  } out_item_t;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] ptr);
    return (ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : ptr + 1'b1;
  endfunction

  // Ring position of head plus offset; the sum stays below twice the depth.
  function automatic logic [PTR_W-1:0] ptr_add(input logic [PTR_W-1:0]  head,
                                               input logic [FILL_W-1:0] off);
    logic [SUM_W-1:0] sum;
    sum = SUM_W'(head) + SUM_W'(off);
    if (sum >= SUM_W'(QUEUE_DEPTH)) begin
      sum = sum - SUM_W'(QUEUE_DEPTH);
    end
    return PTR_W'(sum);
  endfunction

  function automatic logic [ADDR_W-1:0] slot_addr(input logic [SRV_W-1:0] srv,
                                                  input logic [PTR_W-1:0] ptr);
    return ADDR_W'(srv) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(ptr);
  endfunction

endpackage

### rtl/efsd_calc.sv
// Result arithmetic for one job: start, wait, saturated end, status, ahead count.
// Depends on efsd_pkg.
module efsd_calc (
  input  logic                         idle_i,
  input  logic [efsd_pkg::SRV_W-1:0]   srv_i,
  input  logic [efsd_pkg::TIME_W-1:0]  arrival_i,
  input  logic [efsd_pkg::SVC_W-1:0]   service_i,
  input  logic [efsd_pkg::TIME_W-1:0]  closing_i,
  input  logic [efsd_pkg::TIME_W-1:0]  last_finish_i,
  input  logic [efsd_pkg::FILL_W-1:0]  fill_i,
  output efsd_pkg::out_item_t          item_o,
  output logic                         push_o
);
  import efsd_pkg::*;

  localparam int END_W = TIME_W + 1;

  logic [TIME_W-1:0] start_m;
  logic [TIME_W-1:0] wait_m;
  logic [END_W-1:0]  end_sum;
  logic [TIME_W-1:0] end_m;
  status_e           status;

  always_comb begin
    start_m = (idle_i || (last_finish_i < arrival_i)) ? arrival_i : last_finish_i;
    wait_m  = start_m - arrival_i;
    end_sum = END_W'(start_m) + END_W'(service_i);
    end_m   = end_sum[TIME_W] ? TIME_MAX : end_sum[TIME_W-1:0];

    // The closing check only concerns jobs that would have to queue.
    priority if (idle_i) begin
      status = ST_IDLE;
    end else if (start_m >= closing_i) begin
      status = ST_CLOSED;
    end else if (fill_i >= FILL_W'(QUEUE_DEPTH)) begin
      status = ST_FULL;
    end else begin
      status = ST_QUEUED;
    end
  end

  assign push_o = (status == ST_IDLE) || (status == ST_QUEUED);

  assign item_o.server_index = SIDX_W'(srv_i);
  assign item_o.status       = status;
  assign item_o.wait_minutes = wait_m;
  assign item_o.start_minute = start_m;
  assign item_o.end_minute   = end_m;
  assign item_o.ahead_count  = idle_i ? '0 : AHEAD_W'(fill_i);

endmodule

### rtl/earliest_free_server_dispatch.sv
// Earliest-free-server dispatch: one result item for every job item, one item at a time.
// On accept it retires finished queue heads in server order, then takes the lowest-numbered
// empty server or, with none empty, the server whose tail finish time is earliest (tail scan).
// Each retire or tail step is one read of the finish-time memory. The next job is accepted only
// after the result enters the output register, which an output stall can delay.
// Reset empties all queues and sets closing to 1020; the finish-time memory is not cleared.
`include "earliest_free_server_dispatch_assert.svh"

module earliest_free_server_dispatch (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  efsd_pkg::in_item_t          in_item_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output efsd_pkg::out_item_t         out_item_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [efsd_pkg::TIME_W-1:0] cfg_data_i
);
  import efsd_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE     = 8'b0000_0001,
    S_RET_RD   = 8'b0000_0010,
    S_RET_CMP  = 8'b0000_0100,
    S_PICK     = 8'b0000_1000,
    S_TAIL_RD  = 8'b0001_0000,
    S_TAIL_CMP = 8'b0010_0000,
    S_DECIDE   = 8'b0100_0000,
    S_DONE     = 8'b1000_0000
  } state_e;

  state_e            state_q, state_d;
  logic [SRV_W-1:0]  srv_q, srv_d;
  logic [SRV_W-1:0]  best_q, best_d;
  logic [TIME_W-1:0] best_last_q, best_last_d;
  logic              idle_q, idle_d;
  logic [TIME_W-1:0] closing_q;
  logic [TIME_W-1:0] arr_q;
  logic [SVC_W-1:0]  svc_q;

  logic [FILL_W-1:0] fill_q [SERVERS];
  logic [PTR_W-1:0]  head_q [SERVERS];

  logic [TIME_W-1:0] mem [MEM_DEPTH];
  logic [TIME_W-1:0] rdata_q;
  logic              mem_re;
  logic              mem_we;
  logic [ADDR_W-1:0] raddr;
  logic [ADDR_W-1:0] waddr;

  logic              out_valid_q;
  out_item_t         out_item_q;
  out_item_t         res_q;
  out_item_t         calc_item;
  logic              calc_push;
  logic              res_load;
  logic              out_load;

  logic              in_accept;
  logic              pop;
  logic              at_last;
  logic [FILL_W-1:0] fill_sel;
  logic [PTR_W-1:0]  head_sel;
  logic [PTR_W-1:0]  tail_ptr;
  logic [PTR_W-1:0]  push_ptr;
  logic              idle_found;
  logic [SRV_W-1:0]  idle_idx;

  assign in_stall_o  = (state_q != S_IDLE);
  assign in_accept   = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;

  assign fill_sel = fill_q[srv_q];
  assign head_sel = head_q[srv_q];
  assign tail_ptr = ptr_add(head_sel, fill_sel - 1'b1);
  assign push_ptr = ptr_add(head_sel, fill_sel);
  assign at_last  = (srv_q == SRV_W'(SERVERS - 1));

  assign raddr = slot_addr(srv_q, (state_q == S_TAIL_RD) ? tail_ptr : head_sel);
  assign waddr = slot_addr(srv_q, push_ptr);

  // Lowest-numbered server whose queue is empty.
  always_comb begin
    idle_found = 1'b0;
    idle_idx   = '0;
    for (int s = SERVERS - 1; s >= 0; s--) begin
      if (fill_q[s] == '0) begin
        idle_found = 1'b1;
        idle_idx   = SRV_W'(s);
      end
    end
  end

  efsd_calc u_calc (
    .idle_i        (idle_q),
    .srv_i         (srv_q),
    .arrival_i     (arr_q),
    .service_i     (svc_q),
    .closing_i     (closing_q),
    .last_finish_i (best_last_q),
    .fill_i        (fill_sel),
    .item_o        (calc_item),
    .push_o        (calc_push)
  );

  assign out_load = (state_q == S_DONE) && (!out_valid_q || !out_stall_i);

  always_comb begin
    state_d     = state_q;
    srv_d       = srv_q;
    best_d      = best_q;
    best_last_d = best_last_q;
    idle_d      = idle_q;
    mem_re      = 1'b0;
    mem_we      = 1'b0;
    pop         = 1'b0;
    res_load    = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          srv_d   = '0;
          state_d = S_RET_RD;
        end
      end
      S_RET_RD: begin
        if (fill_sel == '0) begin
          if (at_last) begin
            state_d = S_PICK;
          end else begin
            srv_d = srv_q + 1'b1;
          end
        end else begin
          mem_re  = 1'b1;
          state_d = S_RET_CMP;
        end
      end
      S_RET_CMP: begin
        // Finish times within one queue never decrease, so retiring stops at the
        // first head entry that is still in service.
        if (rdata_q <= arr_q) begin
          pop     = 1'b1;
          state_d = S_RET_RD;
        end else if (at_last) begin
          state_d = S_PICK;
        end else begin
          srv_d   = srv_q + 1'b1;
          state_d = S_RET_RD;
        end
      end
      S_PICK: begin
        if (idle_found) begin
          srv_d   = idle_idx;
          idle_d  = 1'b1;
          state_d = S_DECIDE;
        end else begin
          srv_d   = '0;
          idle_d  = 1'b0;
          state_d = S_TAIL_RD;
        end
      end
      S_TAIL_RD: begin
        mem_re  = 1'b1;
        state_d = S_TAIL_CMP;
      end
      S_TAIL_CMP: begin
        if ((srv_q == '0) || (rdata_q < best_last_q)) begin
          best_d      = srv_q;
          best_last_d = rdata_q;
        end
        if (at_last) begin
          srv_d   = best_d;
          state_d = S_DECIDE;
        end else begin
          srv_d   = srv_q + 1'b1;
          state_d = S_TAIL_RD;
        end
      end
      S_DECIDE: begin
        mem_we   = calc_push;
        res_load = 1'b1;
        state_d  = S_DONE;
      end
      S_DONE: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      srv_q       <= '0;
      best_q      <= '0;
      idle_q      <= 1'b0;
      closing_q   <= CLOSING_RESET;
      out_valid_q <= 1'b0;
      for (int s = 0; s < SERVERS; s++) begin
        fill_q[s] <= '0;
        head_q[s] <= '0;
      end
    end else begin
      state_q <= state_d;
      srv_q   <= srv_d;
      best_q  <= best_d;
      idle_q  <= idle_d;
      if (cfg_valid_i && cfg_ready_o) begin
        closing_q <= cfg_data_i;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (pop) begin
        head_q[srv_q] <= ptr_inc(head_sel);
        fill_q[srv_q] <= fill_sel - 1'b1;
      end else if (mem_we) begin
        fill_q[srv_q] <= fill_sel + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    best_last_q <= best_last_d;
    if (in_accept) begin
      arr_q <= in_item_i.arrival_minute;
      svc_q <= in_item_i.service_minutes;
    end
    if (res_load) begin
      res_q <= calc_item;
    end
    if (out_load) begin
      out_item_q <= res_q;
    end
  end

  // Finish-time memory. Reads and writes are never issued in the same cycle,
  // so a read always sees every earlier write.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[waddr] <= calc_item.end_minute;
    end
    if (mem_re) begin
      rdata_q <= mem[raddr];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  `EFSD_ASSERT_SAME(a_no_rw_overlap, mem_we, !mem_re,
                    "finish-time memory read and write in the same cycle")
  `EFSD_ASSERT_SAME(a_push_not_full, mem_we, fill_sel < FILL_W'(QUEUE_DEPTH),
                    "push into a full server queue")
  `EFSD_ASSERT_SAME(a_pop_not_empty, pop, fill_sel != '0,
                    "retire from an empty server queue")
  `EFSD_ASSERT_NEXT(a_accept_starts, in_accept, state_q == S_RET_RD,
                    "accepted item did not start the retire scan")
  `EFSD_ASSERT_SAME(a_result_from_done, $rose(out_valid_o), $past(state_q == S_DONE),
                    "result item appeared without a finished job")

endmodule
